FILE: hw/rtl/dtcw_pkg.sv
// Shared types and constants for the date/time check and weekday block.
// Holds the input and result structs plus the calendar tables.
// No dependencies.
package dtcw_pkg;

    typedef struct packed {
        logic [7:0] month;
        logic [7:0] day;
        logic [6:0] year_two_digit;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
    } t_in;

    typedef struct packed {
        logic        date_ok;
        logic        time_ok;
        logic [2:0]  weekday;
        logic [15:0] days_since_1978;
    } t_out;

    // Days from 1 Jan 1978 to 1 Jan 2000: 22 years, five of them leap.
    localparam logic [15:0] DAYS_TO_2000  = 16'd8035;
    localparam logic [15:0] DAYS_PER_YEAR = 16'd365;
    // 8035 mod 7; 365 mod 7 is 1, so each year advances the weekday by one.
    localparam logic [7:0]  WD_AT_2000    = 8'd6;
    // Two-digit year of 2100, the one century year in range that is not leap.
    localparam logic [6:0]  YY_2100       = 7'd100;
    localparam logic [7:0]  HOURS_PER_DAY = 8'd24;
    localparam logic [7:0]  MIN_PER_HOUR  = 8'd60;
    localparam logic [7:0]  SEC_PER_MIN   = 8'd60;
    localparam logic [7:0]  MONTHS        = 8'd12;
    localparam logic [3:0]  MON_FEB       = 4'd2;

    // Days before the first of month m in a common year.
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] v;
        unique case (m)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // Same table reduced mod 7.
    function automatic logic [2:0] days_before_month_mod7(input logic [3:0] m);
        logic [2:0] v;
        unique case (m)
            4'd1:    v = 3'd0;
            4'd2:    v = 3'd3;
            4'd3:    v = 3'd3;
            4'd4:    v = 3'd6;
            4'd5:    v = 3'd1;
            4'd6:    v = 3'd4;
            4'd7:    v = 3'd6;
            4'd8:    v = 3'd2;
            4'd9:    v = 3'd5;
            4'd10:   v = 3'd0;
            4'd11:   v = 3'd3;
            4'd12:   v = 3'd5;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
        logic [4:0] v;
        unique case (m)
            4'd2:                   v = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: v = 5'd30;
            default:                v = 5'd31;
        endcase
        return v;
    endfunction

    // Reduce an 8-bit value mod 7 by folding octal digits (8 mod 7 is 1).
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [4:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        s1 = 5'(x[7:6]) + 5'(x[5:3]) + 5'(x[2:0]);
        s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
        s3 = 4'(s2[3]) + 4'(s2[2:0]);
        if (s3 >= 4'd7) begin
            s3 = s3 - 4'd7;
        end
        return s3[2:0];
    endfunction

endpackage

FILE: hw/rtl/date_time_check_weekday_top.sv
// Date/time range check with day count and weekday from 1 Jan 1978.
// A start transfer passes the input register, then the result register, to o_done; one item per cycle.
// busy is held low: a new item may be started in every cycle.
// Results are shown on o_result for one cycle under o_done; no stall.
// Reset (i_rst_n low, synchronous) clears the pipeline valid flags only.
// Depends on dtcw_pkg.
module date_time_check_weekday_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  dtcw_pkg::t_in    i_item,
    output logic             busy,
    output logic             o_done,
    output dtcw_pkg::t_out   o_result
);

    // Input register stage
    logic            r_in_vld;
    dtcw_pkg::t_in   r_in;

    // Result register stage
    logic            r_out_vld;
    dtcw_pkg::t_out  r_out;
    dtcw_pkg::t_out  n_out;

    // Decode helpers
    logic [3:0]  mon;
    logic [6:0]  yy;
    logic        leap;
    logic        month_ok;
    logic [4:0]  mlen;
    logic        day_ok;
    logic        date_ok;
    logic        time_ok;
    logic        late_leap;
    logic [4:0]  day_m1;
    logic [5:0]  leaps_since_2000;
    logic [15:0] year_days;
    logic [15:0] days;
    logic [7:0]  wd_sum;
    logic [2:0]  wd_mod;

    // Never back-pressure the requester: the datapath is a single pass.
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start && !busy;
            r_out_vld <= r_in_vld;
        end
    end

    // Payload registers: capture on every transfer, no reset needed.
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_item;
        end
        if (r_in_vld) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        mon      = r_in.month[3:0];
        yy       = r_in.year_two_digit;
        // Within 2000..2127 only 2100 breaks the divisible-by-4 rule.
        leap     = (yy[1:0] == 2'b00) && (yy != dtcw_pkg::YY_2100);
        month_ok = (r_in.month >= 8'd1) && (r_in.month <= dtcw_pkg::MONTHS);
        mlen     = dtcw_pkg::month_length(mon, leap);
        day_ok   = (r_in.day >= 8'd1) && (r_in.day <= {3'b000, mlen});
        date_ok  = month_ok && day_ok;
        time_ok  = (r_in.hour   < dtcw_pkg::HOURS_PER_DAY) &&
                   (r_in.minute < dtcw_pkg::MIN_PER_HOUR)  &&
                   (r_in.second < dtcw_pkg::SEC_PER_MIN);

        late_leap = leap && (mon > dtcw_pkg::MON_FEB);
        day_m1    = 5'(r_in.day - 8'd1);

        // Leap years in 2000..(2000+yy-1): ceil(yy/4), less one past 2100.
        leaps_since_2000 = 6'((8'(yy) + 8'd3) >> 2) -
                           6'(yy > dtcw_pkg::YY_2100);

        year_days = 16'(yy) * dtcw_pkg::DAYS_PER_YEAR;
        days      = dtcw_pkg::DAYS_TO_2000 + year_days + 16'(leaps_since_2000) +
                    16'(dtcw_pkg::days_before_month(mon)) + 16'(late_leap) +
                    16'(day_m1);

        // Weekday from residues, avoiding a wide mod-7 on the day count.
        wd_sum = 8'(day_m1) + 8'(dtcw_pkg::days_before_month_mod7(mon)) +
                 8'(late_leap) + dtcw_pkg::WD_AT_2000 + 8'(yy) +
                 8'(leaps_since_2000);
        wd_mod = dtcw_pkg::mod7(wd_sum);

        n_out.date_ok         = date_ok;
        n_out.time_ok         = time_ok;
        // Day 0 is a Sunday, which reports as 7.
        n_out.weekday         = !date_ok ? 3'd0 : ((wd_mod == 3'd0) ? 3'd7 : wd_mod);
        n_out.days_since_1978 = date_ok ? days : 16'd0;
    end

    assign o_done   = r_out_vld;
    assign o_result = r_out;

    // Every captured item comes out on o_done in the next cycle.
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |=> o_done)
        else $error("captured item did not produce a result");

    a_start_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> r_in_vld)
        else $error("started item was not captured");

    a_bad_date_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.date_ok) |->
            (o_result.weekday == 3'd0) && (o_result.days_since_1978 == 16'd0))
        else $error("invalid date with nonzero day fields");

    a_good_date_wd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.date_ok) |->
            (o_result.weekday != 3'd0) && (o_result.days_since_1978 >= 16'd8035))
        else $error("valid date with out-of-range weekday or day count");

endmodule
